/* hw/rtl/weighted_score_multilevel_queue_assert.svh */
// ----------------------------------------------------------------------------
// weighted_score_multilevel_queue assertion macros
// Concurrent assertion wrappers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SCORE_MULTILEVEL_QUEUE_ASSERT_SVH
`define WEIGHTED_SCORE_MULTILEVEL_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define WSMLQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wsmlq assertion failed");
`define WSMLQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("wsmlq assertion failed");
`else
`define WSMLQ_ASSERT(lbl, clk, rst, prop)
`define WSMLQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/wsmlq_pkg.sv */
// ----------------------------------------------------------------------------
// wsmlq_pkg
// Shared widths, codes and types of the weighted score multilevel queue.
// ----------------------------------------------------------------------------
package wsmlq_pkg;

   localparam int NUM_FEAT       = 8;
   localparam int FEAT_W         = 9;
   localparam int FEAT_IDX_W     = 3;
   localparam int ID_W           = 8;
   localparam int SCORE_W        = 9;
   localparam int STATUS_W       = 2;
   localparam int LEVEL_OUT_W    = 2;
   localparam int LVL_MAX_W      = 4;
   localparam int CSR_IDX_W      = 4;
   localparam int Q8_SHIFT       = 8;
   localparam int Q8_ONE         = 256;
   localparam int BOOST_Q8       = 307;
   localparam int EMERGENT_LIMIT = 128;
   localparam int EMERGENT_IDX   = 7;

   localparam int LEVELS_DEFAULT     = 4;
   localparam int FIFO_DEPTH_DEFAULT = 16;
   localparam int CMDQ_DEPTH_DEFAULT = 2;
   localparam int RAM_WIDTH_DEFAULT  = ID_W;
   localparam int RAM_DEPTH_DEFAULT  = LEVELS_DEFAULT * FIFO_DEPTH_DEFAULT;

   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   typedef logic [NUM_FEAT-1:0][FEAT_W-1:0] q8_vec_type;

   // index 0 is the load weight
   localparam q8_vec_type WEIGHT_RESET = {9'd13, 9'd13, 9'd13, 9'd38,
                                          9'd64, 9'd26, 9'd38, 9'd51};

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_DEQ    = 2'd0,
      OP_ENQ    = 2'd1,
      OP_IGNORE = 2'd2
   } op_type;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   task_id;
      logic              managed;
      q8_vec_type        feat;
   } request_type;

   typedef struct packed {
      op_type                op;
      logic [ID_W-1:0]       task_id;
      logic [LVL_MAX_W-1:0]  level;
      logic [SCORE_W-1:0]    score;
   } cmd_type;

   typedef struct packed {
      status_type              status;
      logic [ID_W-1:0]         task_id;
      logic [LEVEL_OUT_W-1:0]  level;
      logic [SCORE_W-1:0]      score;
   } rsp_type;

endpackage

/* hw/rtl/wsmlq_req_if.sv */
// ----------------------------------------------------------------------------
// wsmlq_req_if
// Request channel: enqueue or dequeue items with task id and features.
// ----------------------------------------------------------------------------
interface wsmlq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [wsmlq_pkg::ID_W-1:0]    task_id;
   logic                          managed;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_load;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_memory;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_io;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_interactive;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_realtime;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_network;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_priority;
   logic [wsmlq_pkg::FEAT_W-1:0]  feat_emergent;

   modport source (
      output valid, req_type, task_id, managed, feat_load, feat_memory, feat_io,
             feat_interactive, feat_realtime, feat_network, feat_priority,
             feat_emergent,
      input  ready
   );
   modport sink (
      input  valid, req_type, task_id, managed, feat_load, feat_memory, feat_io,
             feat_interactive, feat_realtime, feat_network, feat_priority,
             feat_emergent,
      output ready
   );
endinterface

/* hw/rtl/wsmlq_rsp_if.sv */
// ----------------------------------------------------------------------------
// wsmlq_rsp_if
// Result channel: status, task id, level and score of each request.
// ----------------------------------------------------------------------------
interface wsmlq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [wsmlq_pkg::STATUS_W-1:0]     status;
   logic [wsmlq_pkg::ID_W-1:0]         out_task_id;
   logic [wsmlq_pkg::LEVEL_OUT_W-1:0]  out_level;
   logic [wsmlq_pkg::SCORE_W-1:0]      score;

   modport source (
      output valid, status, out_task_id, out_level, score,
      input  ready
   );
   modport sink (
      input  valid, status, out_task_id, out_level, score,
      output ready
   );
endinterface

/* hw/rtl/wsmlq_csr_if.sv */
// ----------------------------------------------------------------------------
// wsmlq_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wsmlq_csr_if;
   logic                              valid;
   logic                              ready;
   logic [wsmlq_pkg::CSR_IDX_W-1:0]   index;
   logic [wsmlq_pkg::FEAT_W-1:0]      data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

/* hw/rtl/weighted_score_multilevel_queue.sv */
// ----------------------------------------------------------------------------
// weighted_score_multilevel_queue
// Multilevel priority queue with weighted feature scoring of enqueued tasks.
// ----------------------------------------------------------------------------
// Each request passes a scoring pipeline (products, partial sums, Q8 sum,
// boost/clamp/level pick), then a two-entry command queue, then the back end
// that owns the level FIFOs. The back end takes one request per cycle while
// its result register is free, except a dequeue that finds a non-empty
// level, which also passes a wait state because the popped id comes from the
// registered read of the shared FIFO RAM. A result passes the scoring
// pipeline, the command queue and the result register, and a dequeue that
// finds an id also the RAM read register. While a result waits in the output
// register, up to six more requests are taken into the scoring pipeline and
// the command queue before the request side stalls. The FIFO RAM needs no
// clearing after reset, so the block accepts requests right away. Weights are
// written through the csr channel, indices 0..7; other indices are ignored.
module weighted_score_multilevel_queue #(
   parameter int LEVELS     = wsmlq_pkg::LEVELS_DEFAULT,
   parameter int FIFO_DEPTH = wsmlq_pkg::FIFO_DEPTH_DEFAULT,
   parameter int CMDQ_DEPTH = wsmlq_pkg::CMDQ_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   wsmlq_req_if.sink          req_bus,
   wsmlq_rsp_if.source        rsp_bus,
   wsmlq_csr_if.sink          csr_bus
);
   import wsmlq_pkg::*;

   q8_vec_type   weights_ff;
   request_type  req;
   logic         push_valid, push_ready, pop_valid, pop_ready;
   cmd_type      push_cmd, pop_cmd;
   rsp_type      rsp_data;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= WEIGHT_RESET;
      end else if (csr_bus.valid && csr_bus.index < CSR_IDX_W'(NUM_FEAT)) begin
         weights_ff[csr_bus.index[FEAT_IDX_W-1:0]] <= csr_bus.data;
      end
   end

   always_comb begin
      req.kind    = req_bus.req_type;
      req.task_id = req_bus.task_id;
      req.managed = req_bus.managed;
      req.feat    = {req_bus.feat_emergent, req_bus.feat_priority, req_bus.feat_network,
                     req_bus.feat_realtime, req_bus.feat_interactive, req_bus.feat_io,
                     req_bus.feat_memory, req_bus.feat_load};
   end

   wsmlq_front #(
      .LEVELS (LEVELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req        (req),
      .weights    (weights_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   wsmlq_cmd_queue #(
      .DEPTH (CMDQ_DEPTH)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   wsmlq_back #(
      .LEVELS     (LEVELS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.status      = rsp_data.status;
   assign rsp_bus.out_task_id = rsp_data.task_id;
   assign rsp_bus.out_level   = rsp_data.level;
   assign rsp_bus.score       = rsp_data.score;
endmodule

/* hw/rtl/wsmlq_ram.sv */
// ----------------------------------------------------------------------------
// wsmlq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wsmlq_ram #(
   parameter int WIDTH = wsmlq_pkg::RAM_WIDTH_DEFAULT,
   parameter int DEPTH = wsmlq_pkg::RAM_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/wsmlq_front.sv */
// ----------------------------------------------------------------------------
// wsmlq_front
// Classifies requests and scores enqueues in a four stage pipeline:
// products, partial sums, Q8 sum, then boost, clamp and level pick.
// ----------------------------------------------------------------------------
module wsmlq_front #(
   parameter int LEVELS = wsmlq_pkg::LEVELS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wsmlq_pkg::request_type  req,
   input  wsmlq_pkg::q8_vec_type   weights,
   output logic                    push_valid,
   input  logic                    push_ready,
   output wsmlq_pkg::cmd_type      push_cmd
);
   import wsmlq_pkg::*;

   localparam int LVL_W   = $clog2(LEVELS);
   localparam int PROD_W  = 2 * FEAT_W;
   localparam int HALF_N  = NUM_FEAT / 2;
   localparam int HALF_W  = PROD_W + $clog2(HALF_N);
   localparam int ACC_W   = HALF_W + 1;
   localparam int BASE_W  = ACC_W - Q8_SHIFT;
   localparam int BOOST_W = BASE_W + FEAT_W;
   localparam int BST_W   = BOOST_W - Q8_SHIFT;
   localparam int SCALE_W = SCORE_W + LVL_W;

   typedef struct packed {
      op_type           op;
      logic [ID_W-1:0]  task_id;
      logic             boost;
   } front_tag_type;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic                advance;
   front_tag_type       tag_in, tag1_ff, tag2_ff, tag3_ff;
   logic [PROD_W-1:0]   prod_in [NUM_FEAT];
   logic [PROD_W-1:0]   prod_ff [NUM_FEAT];
   logic [HALF_W-1:0]   half_in [2];
   logic [HALF_W-1:0]   half_ff [2];
   logic [ACC_W-1:0]    total;
   logic [BASE_W-1:0]   base_in, base_ff;
   logic [BOOST_W-1:0]  boost_prod;
   logic [BST_W-1:0]    boosted;
   logic [SCORE_W-1:0]  score_in;
   logic [SCALE_W-1:0]  scaled;
   logic [LVL_W-1:0]    lvl_pick;
   cmd_type             cmd_in, cmd_ff;

   // the whole pipe holds when its last stage cannot push
   assign advance   = !out_valid_ff || push_ready;
   assign req_ready = advance;

   always_comb begin
      if (req.kind == REQ_DEQ) begin
         tag_in.op = OP_DEQ;
      end else if (req.managed) begin
         tag_in.op = OP_ENQ;
      end else begin
         tag_in.op = OP_IGNORE;
      end
      tag_in.task_id = req.task_id;
      tag_in.boost   = req.feat[EMERGENT_IDX] > FEAT_W'(EMERGENT_LIMIT);
      for (int i = 0; i < NUM_FEAT; i++) begin
         prod_in[i] = PROD_W'(req.feat[i]) * PROD_W'(weights[i]);
      end
   end

   always_comb begin
      for (int h = 0; h < 2; h++) begin
         half_in[h] = '0;
         for (int k = 0; k < HALF_N; k++) begin
            half_in[h] = half_in[h] + HALF_W'(prod_ff[h * HALF_N + k]);
         end
      end
      total   = ACC_W'(half_ff[0]) + ACC_W'(half_ff[1]);
      base_in = total[ACC_W-1:Q8_SHIFT];
   end

   always_comb begin
      boost_prod = BOOST_W'(base_ff) * BOOST_W'(BOOST_Q8);
      if (tag3_ff.boost) begin
         boosted = boost_prod[BOOST_W-1:Q8_SHIFT];
      end else begin
         boosted = BST_W'(base_ff);
      end
      if (boosted > BST_W'(Q8_ONE)) begin
         score_in = SCORE_W'(Q8_ONE);
      end else begin
         score_in = boosted[SCORE_W-1:0];
      end
      // first level whose threshold the scaled score reaches
      scaled   = SCALE_W'(score_in) * SCALE_W'(LEVELS);
      lvl_pick = LVL_W'(LEVELS - 1);
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (scaled >= SCALE_W'((LEVELS - i) * Q8_ONE)) begin
            lvl_pick = LVL_W'(i);
         end
      end
      cmd_in.op      = tag3_ff.op;
      cmd_in.task_id = tag3_ff.task_id;
      cmd_in.level   = LVL_MAX_W'(lvl_pick);
      cmd_in.score   = score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         tag1_ff <= tag_in;
         half_ff <= half_in;
         tag2_ff <= tag1_ff;
         base_ff <= base_in;
         tag3_ff <= tag2_ff;
         cmd_ff  <= cmd_in;
      end
   end

   assign push_valid = out_valid_ff;
   assign push_cmd   = cmd_ff;
endmodule

/* hw/rtl/wsmlq_cmd_queue.sv */
// ----------------------------------------------------------------------------
// wsmlq_cmd_queue
// Short command queue between the scoring front and the queue back end.
// ----------------------------------------------------------------------------
module wsmlq_cmd_queue #(
   parameter int DEPTH = wsmlq_pkg::CMDQ_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  wsmlq_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output wsmlq_pkg::cmd_type  pop_cmd
);
   import wsmlq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

/* hw/rtl/wsmlq_back.sv */
// ----------------------------------------------------------------------------
// wsmlq_back
// Executes commands against the per-level FIFOs held in one shared RAM and
// drives the result register.
// ----------------------------------------------------------------------------
module wsmlq_back #(
   parameter int LEVELS     = wsmlq_pkg::LEVELS_DEFAULT,
   parameter int FIFO_DEPTH = wsmlq_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  wsmlq_pkg::cmd_type  cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wsmlq_pkg::rsp_type  rsp_data
);
   import wsmlq_pkg::*;

   `include "weighted_score_multilevel_queue_assert.svh"

   localparam int LVL_W    = $clog2(LEVELS);
   localparam int PTR_W    = $clog2(FIFO_DEPTH);
   localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
   localparam int RAM_DEPTH = LEVELS * FIFO_DEPTH;
   localparam int ADDR_W   = $clog2(RAM_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WAIT = 2'b10
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [PTR_W-1:0]       head_ff [LEVELS];
   logic [PTR_W-1:0]       head_in [LEVELS];
   logic [PTR_W-1:0]       tail_ff [LEVELS];
   logic [PTR_W-1:0]       tail_in [LEVELS];
   logic [CNT_W-1:0]       fill_ff [LEVELS];
   logic [CNT_W-1:0]       fill_in [LEVELS];
   logic [LVL_W-1:0]       pend_lvl_ff, pend_lvl_in;
   logic [LVL_MAX_W-1:0]   pend_lvl_ext;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_load;
   rsp_type                rsp_ff, rsp_in;
   logic                   out_free, take;
   logic [LVL_W-1:0]       deq_lvl, enq_lvl;
   logic                   any_ne, enq_full, fill_over;
   logic                   deq_hit, deq_miss, pop_done, pop_ok;
   logic                   ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [ID_W-1:0]        ram_rd_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;
   assign enq_lvl   = cmd.level[LVL_W-1:0];
   assign enq_full  = fill_ff[enq_lvl] == CNT_W'(FIFO_DEPTH);
   assign pend_lvl_ext = LVL_MAX_W'(pend_lvl_ff);

   // highest non-empty level, level 0 first
   always_comb begin
      deq_lvl   = '0;
      any_ne    = 1'b0;
      fill_over = 1'b0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (fill_ff[l] != '0) begin
            deq_lvl = LVL_W'(l);
            any_ne  = 1'b1;
         end
         if (fill_ff[l] > CNT_W'(FIFO_DEPTH)) begin
            fill_over = 1'b1;
         end
      end
   end

   assign ram_rd_addr = ADDR_W'(deq_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_ff[deq_lvl]);
   assign ram_wr_addr = ADDR_W'(enq_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(tail_ff[enq_lvl]);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      pend_lvl_in    = pend_lvl_ff;
      rsp_load       = 1'b0;
      rsp_in.status  = ST_OK;
      rsp_in.task_id = cmd.task_id;
      rsp_in.level   = '0;
      rsp_in.score   = '0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (cmd.op)
                  OP_DEQ: begin
                     if (any_ne) begin
                        ram_rd_en   = 1'b1;
                        pend_lvl_in = deq_lvl;
                        head_in[deq_lvl] = (head_ff[deq_lvl] == PTR_W'(FIFO_DEPTH - 1)) ?
                                           '0 : head_ff[deq_lvl] + 1'b1;
                        fill_in[deq_lvl] = fill_ff[deq_lvl] - 1'b1;
                        state_in    = S_WAIT;
                     end else begin
                        rsp_load       = 1'b1;
                        rsp_in.status  = ST_EMPTY;
                        rsp_in.task_id = '0;
                     end
                  end
                  OP_ENQ: begin
                     rsp_load     = 1'b1;
                     rsp_in.level = cmd.level[LEVEL_OUT_W-1:0];
                     rsp_in.score = cmd.score;
                     if (enq_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        tail_in[enq_lvl] = (tail_ff[enq_lvl] == PTR_W'(FIFO_DEPTH - 1)) ?
                                           '0 : tail_ff[enq_lvl] + 1'b1;
                        fill_in[enq_lvl] = fill_ff[enq_lvl] + 1'b1;
                     end
                  end
                  OP_IGNORE: begin
                     rsp_load      = 1'b1;
                     rsp_in.status = ST_IGNORED;
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_in.status = ST_IGNORED;
                  end
               endcase
            end
         end
         S_WAIT: begin
            // popped id arrives from the registered ram read
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_in.task_id = ram_rd_data;
               rsp_in.level   = pend_lvl_ext[LEVEL_OUT_W-1:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_lvl_ff <= pend_lvl_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   wsmlq_ram #(
      .WIDTH (ID_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cmd.task_id),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign deq_hit  = take && cmd.op == OP_DEQ && any_ne;
   assign deq_miss = take && cmd.op == OP_DEQ && !any_ne;
   assign pop_done = state_ff == S_WAIT && out_free;
   assign pop_ok   = rsp_valid_ff && rsp_ff.status == ST_OK && rsp_ff.score == '0;

   `WSMLQ_ASSERT(a_fill_bound, clock, reset, !fill_over)
   `WSMLQ_ASSERT(a_pop_waits, clock, reset, deq_hit |=> (state_ff == S_WAIT && !rsp_valid_ff))
   `WSMLQ_ASSERT(a_pop_result, clock, reset, pop_done |=> pop_ok)
   `WSMLQ_ASSERT(a_empty_flag, clock, reset, deq_miss |=> (rsp_valid_ff && rsp_ff.status == ST_EMPTY))
endmodule

/* verif/tb_weighted_score_multilevel_queue.sv */
// ----------------------------------------------------------------------------
// tb_weighted_score_multilevel_queue
// Self-checking bench: drives enqueue/dequeue items and weight writes, keeps
// its own scoring and level FIFO model, checks every result item in order.
// ----------------------------------------------------------------------------
module tb_weighted_score_multilevel_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import wsmlq_pkg::*;

   localparam int LEVELS         = LEVELS_DEFAULT;
   localparam int DEPTH          = FIFO_DEPTH_DEFAULT;
   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RAND_PHASES    = 7;
   localparam int QUIET_PHASE    = 3;
   localparam int PHASE_ITEMS    = 110;
   localparam int TAIL_ITEMS     = 50;
   localparam int FEAT_MAX       = (1 << FEAT_W) - 1;

   // weight register indexes
   localparam int WSEL_LOAD        = 0;
   localparam int WSEL_MEMORY      = 1;
   localparam int WSEL_IO          = 2;
   localparam int WSEL_INTERACTIVE = 3;
   localparam int WSEL_REALTIME    = 4;
   localparam int WSEL_NETWORK     = 5;
   localparam int WSEL_PRIORITY    = 6;
   localparam int WSEL_EMERGENT    = 7;
   localparam int WSEL_UNUSED_LO   = NUM_FEAT;
   localparam int WSEL_UNUSED_HI   = (1 << CSR_IDX_W) - 1;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [FEAT_W-1:0]    data;
   } weight_write_type;

   logic clock;
   logic reset;

   wsmlq_req_if req_ch();
   wsmlq_rsp_if rsp_ch();
   wsmlq_csr_if csr_ch();

   weighted_score_multilevel_queue uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   request_type      req_backlog[$];
   weight_write_type weight_writes[$];
   rsp_type          awaited_rsp[$];
   logic [ID_W-1:0]  level_fifo[LEVELS][$];
   logic [FEAT_W-1:0] weight[NUM_FEAT];

   int errors       = 0;
   int req_gap      = 0;
   int rsp_stall    = 0;
   int quiet_cycles = 0;
   bit req_fired    = 1'b0;
   bit rsp_fired    = 1'b0;
   bit csr_fired    = 1'b0;
   bit bubbles_on   = 1'b0;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic logic [SCORE_W-1:0] task_score(q8_vec_type f);
      logic [31:0] acc;
      logic [31:0] s;
      acc = '0;
      for (int i = 0; i < NUM_FEAT; i++) acc += 32'(f[i]) * 32'(weight[i]);
      s = acc >> Q8_SHIFT;
      if (f[EMERGENT_IDX] > EMERGENT_LIMIT) s = (s * BOOST_Q8) >> Q8_SHIFT;
      if (s > Q8_ONE) s = Q8_ONE;
      return SCORE_W'(s);
   endfunction

   function automatic int score_level(logic [SCORE_W-1:0] sc);
      for (int i = 0; i < LEVELS; i++)
         if (int'(sc) * LEVELS >= (LEVELS - i) * Q8_ONE) return i;
      return LEVELS - 1;
   endfunction

   function automatic rsp_type scheduler_outcome(request_type r);
      rsp_type res;
      int lv;
      res.status  = ST_OK;
      res.task_id = r.task_id;
      res.level   = '0;
      res.score   = '0;
      if (r.kind == REQ_DEQ) begin
         for (int l = 0; l < LEVELS; l++) begin
            if (level_fifo[l].size() > 0) begin
               res.task_id = level_fifo[l].pop_front();
               res.level   = LEVEL_OUT_W'(l);
               return res;
            end
         end
         res.status  = ST_EMPTY;
         res.task_id = '0;
         return res;
      end
      if (!r.managed) begin
         res.status = ST_IGNORED;
         return res;
      end
      res.score = task_score(r.feat);
      lv        = score_level(res.score);
      res.level = LEVEL_OUT_W'(lv);
      if (level_fifo[lv].size() >= DEPTH) res.status = ST_FULL;
      else level_fifo[lv].push_back(r.task_id);
      return res;
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic q8_vec_type same_feat(logic [FEAT_W-1:0] v);
      q8_vec_type f;
      for (int i = 0; i < NUM_FEAT; i++) f[i] = v;
      return f;
   endfunction

   // mostly in the Q8 range, a quarter over the full field width
   function automatic q8_vec_type rand_feat();
      q8_vec_type f;
      for (int i = 0; i < NUM_FEAT; i++)
         f[i] = ($urandom_range(0, 3) == 0) ? FEAT_W'($urandom_range(0, FEAT_MAX))
                                            : FEAT_W'($urandom_range(0, Q8_ONE));
      return f;
   endfunction

   function automatic request_type enq_req(logic [ID_W-1:0] id, logic managed,
                                           q8_vec_type f);
      request_type r;
      r.kind    = REQ_ENQ;
      r.task_id = id;
      r.managed = managed;
      r.feat    = f;
      return r;
   endfunction

   // dequeue with junk in the unused fields
   function automatic request_type deq_req();
      request_type r;
      r      = enq_req(ID_W'($urandom), 1'($urandom), rand_feat());
      r.kind = REQ_DEQ;
      return r;
   endfunction

   function automatic int pick_weight();
      case ($urandom_range(0, 15))
         0, 1:    return 0;
         2, 3:    return Q8_ONE;
         4:       return FEAT_MAX;
         default: return $urandom_range(0, 80);
      endcase
   endfunction

   task automatic write_weight(int idx, int val);
      weight_write_type w;
      w.index = CSR_IDX_W'(idx);
      w.data  = FEAT_W'(val);
      weight_writes.push_back(w);
   endtask

   task automatic queue_traffic(int target);
      int counted;
      int n;
      int pick;
      q8_vec_type f;
      counted = 0;
      while (counted < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // same features, same level: can run the level past its depth
               f = rand_feat();
               n = $urandom_range(12, 20);
               repeat (n) req_backlog.push_back(enq_req(ID_W'($urandom), 1'b1, f));
               counted += n;
            end
            3, 4: begin
               n = $urandom_range(8, 32);
               repeat (n) req_backlog.push_back(deq_req());
               counted += n;
            end
            9: begin
               repeat ($urandom_range(1, 4))
                  req_backlog.push_back(enq_req(ID_W'($urandom), 1'b0, rand_feat()));
            end
            default: begin
               n = $urandom_range(4, 16);
               repeat (n) begin
                  pick = $urandom_range(0, 19);
                  if (pick < 11) begin
                     req_backlog.push_back(enq_req(ID_W'($urandom), 1'b1, rand_feat()));
                     counted++;
                  end else if (pick < 18) begin
                     req_backlog.push_back(deq_req());
                     counted++;
                  end else begin
                     req_backlog.push_back(enq_req(ID_W'($urandom), 1'b0, rand_feat()));
                  end
               end
            end
         endcase
      end
   endtask

   // step just past the rising edge, clear of the clocked processes
   task automatic tick();
      @(posedge clock);
      #1;
   endtask

   task automatic drain();
      do tick(); while (req_backlog.size() > 0 || req_ch.valid || awaited_rsp.size() > 0);
      repeat (SETTLE_CYCLES) tick();
   endtask

   task automatic wait_weights();
      do tick(); while (weight_writes.size() > 0 || csr_ch.valid);
   endtask

   // ------------------------------------------------------------- drivers

   always @(negedge clock) begin : req_driver
      request_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (bubbles_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 18);
            req_ch.valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            r = req_backlog.pop_front();
            req_ch.req_type         <= r.kind;
            req_ch.task_id          <= r.task_id;
            req_ch.managed          <= r.managed;
            req_ch.feat_load        <= r.feat[WSEL_LOAD];
            req_ch.feat_memory      <= r.feat[WSEL_MEMORY];
            req_ch.feat_io          <= r.feat[WSEL_IO];
            req_ch.feat_interactive <= r.feat[WSEL_INTERACTIVE];
            req_ch.feat_realtime    <= r.feat[WSEL_REALTIME];
            req_ch.feat_network     <= r.feat[WSEL_NETWORK];
            req_ch.feat_priority    <= r.feat[WSEL_PRIORITY];
            req_ch.feat_emergent    <= r.feat[WSEL_EMERGENT];
            req_ch.valid            <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_driver
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else if (bubbles_on && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(0, 18);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(negedge clock) begin : csr_driver
      weight_write_type w;
      if (reset) begin
         csr_ch.valid <= 1'b0;
      end else if (!csr_ch.valid || csr_fired) begin
         if (weight_writes.size() > 0) begin
            w = weight_writes.pop_front();
            csr_ch.index <= w.index;
            csr_ch.data  <= w.data;
            csr_ch.valid <= 1'b1;
         end else begin
            csr_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      rsp_type     want;
      request_type r;
      req_fired = !reset && req_ch.valid && req_ch.ready;
      rsp_fired = !reset && rsp_ch.valid && rsp_ch.ready;
      csr_fired = !reset && csr_ch.valid && csr_ch.ready;

      if (rsp_fired) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected result item: status %0d task %0d", rsp_ch.status,
                   rsp_ch.out_task_id);
            errors++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.out_task_id !== want.task_id) begin
               $error("out_task_id: expected %0d, got %0d", want.task_id,
                      rsp_ch.out_task_id);
               errors++;
            end
            if (rsp_ch.out_level !== want.level) begin
               $error("out_level: expected %0d, got %0d", want.level, rsp_ch.out_level);
               errors++;
            end
            if (rsp_ch.score !== want.score) begin
               $error("score: expected %0d, got %0d", want.score, rsp_ch.score);
               errors++;
            end
         end
      end

      // indexes past the weight bank are dropped by the block
      if (csr_fired && csr_ch.index < NUM_FEAT)
         weight[csr_ch.index[FEAT_IDX_W-1:0]] = csr_ch.data;

      if (req_fired) begin
         r.kind                   = req_ch.req_type;
         r.task_id                = req_ch.task_id;
         r.managed                = req_ch.managed;
         r.feat[WSEL_LOAD]        = req_ch.feat_load;
         r.feat[WSEL_MEMORY]      = req_ch.feat_memory;
         r.feat[WSEL_IO]          = req_ch.feat_io;
         r.feat[WSEL_INTERACTIVE] = req_ch.feat_interactive;
         r.feat[WSEL_REALTIME]    = req_ch.feat_realtime;
         r.feat[WSEL_NETWORK]     = req_ch.feat_network;
         r.feat[WSEL_PRIORITY]    = req_ch.feat_priority;
         r.feat[WSEL_EMERGENT]    = req_ch.feat_emergent;
         awaited_rsp.push_back(scheduler_outcome(r));
      end

      if (reset || req_fired || rsp_fired || csr_fired) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main

   initial begin : stimulus
      q8_vec_type f;

      req_ch.valid            = 1'b0;
      req_ch.req_type         = REQ_ENQ;
      req_ch.task_id          = '0;
      req_ch.managed          = 1'b0;
      req_ch.feat_load        = '0;
      req_ch.feat_memory      = '0;
      req_ch.feat_io          = '0;
      req_ch.feat_interactive = '0;
      req_ch.feat_realtime    = '0;
      req_ch.feat_network     = '0;
      req_ch.feat_priority    = '0;
      req_ch.feat_emergent    = '0;
      rsp_ch.ready            = 1'b0;
      csr_ch.valid            = 1'b0;
      csr_ch.index            = '0;
      csr_ch.data             = '0;

      weight[WSEL_LOAD]        = 9'd51;
      weight[WSEL_MEMORY]      = 9'd38;
      weight[WSEL_IO]          = 9'd26;
      weight[WSEL_INTERACTIVE] = 9'd64;
      weight[WSEL_REALTIME]    = 9'd38;
      weight[WSEL_NETWORK]     = 9'd13;
      weight[WSEL_PRIORITY]    = 9'd13;
      weight[WSEL_EMERGENT]    = 9'd13;

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      #1;

      // power-up weights: empty pop, ignored push, score extremes, boost edge
      req_backlog.push_back(deq_req());
      req_backlog.push_back(enq_req(8'hFF, 1'b0, same_feat(FEAT_W'(FEAT_MAX))));
      req_backlog.push_back(enq_req(8'h00, 1'b1, same_feat('0)));
      req_backlog.push_back(enq_req(8'hFF, 1'b1, same_feat(FEAT_W'(Q8_ONE))));
      req_backlog.push_back(enq_req(8'h5A, 1'b1, same_feat(FEAT_W'(FEAT_MAX))));
      f = same_feat(9'd200);
      f[EMERGENT_IDX] = FEAT_W'(EMERGENT_LIMIT);
      req_backlog.push_back(enq_req(8'h11, 1'b1, f));
      f[EMERGENT_IDX] = FEAT_W'(EMERGENT_LIMIT + 1);
      req_backlog.push_back(enq_req(8'h12, 1'b1, f));
      repeat (6) req_backlog.push_back(deq_req());
      drain();

      // score follows feat_load and the boost alone, so the level thresholds can be hit exactly
      write_weight(WSEL_LOAD, Q8_ONE);
      for (int i = WSEL_MEMORY; i <= WSEL_EMERGENT; i++) write_weight(i, 0);
      write_weight(WSEL_UNUSED_LO, FEAT_MAX);
      write_weight(WSEL_UNUSED_HI, FEAT_MAX);
      wait_weights();
      f = '0;
      for (int v = 0; v < 8; v++) begin
         f[WSEL_LOAD] = FEAT_W'(Q8_ONE - (v / 2) * (Q8_ONE / LEVELS) - (v % 2));
         req_backlog.push_back(enq_req(ID_W'($urandom), 1'b1, f));
      end
      f[WSEL_LOAD]    = 9'd214;
      f[EMERGENT_IDX] = FEAT_W'(EMERGENT_LIMIT + 1);
      req_backlog.push_back(enq_req(ID_W'($urandom), 1'b1, f));
      f[WSEL_LOAD]    = FEAT_W'(FEAT_MAX);
      f[EMERGENT_IDX] = '0;
      req_backlog.push_back(enq_req(ID_W'($urandom), 1'b1, f));
      repeat (3) req_backlog.push_back(deq_req());

      for (int p = 0; p < RAND_PHASES; p++) begin
         drain();
         for (int i = 0; i < NUM_FEAT; i++) write_weight(i, pick_weight());
         if ($urandom_range(0, 1) == 1)
            write_weight($urandom_range(WSEL_UNUSED_LO, WSEL_UNUSED_HI),
                         $urandom_range(0, FEAT_MAX));
         wait_weights();
         bubbles_on = (p != QUIET_PHASE);
         queue_traffic(PHASE_ITEMS);
      end

      // tail runs at full rate on both sides
      drain();
      bubbles_on = 1'b0;
      queue_traffic(TAIL_ITEMS);
      drain();

      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/wsmlq_pkg.sv
hw/rtl/wsmlq_req_if.sv
hw/rtl/wsmlq_rsp_if.sv
hw/rtl/wsmlq_csr_if.sv
hw/rtl/wsmlq_ram.sv
hw/rtl/wsmlq_front.sv
hw/rtl/wsmlq_cmd_queue.sv
hw/rtl/wsmlq_back.sv
hw/rtl/weighted_score_multilevel_queue.sv
verif/tb_weighted_score_multilevel_queue.sv
